// ===== src/jbt_pkg.sv =====
// Shared types and constants for the JSON byte tokenizer.
// Used by jbt_lex_step and json_byte_tokenizer; depends on nothing else.
`default_nettype none

package jbt_pkg;

  localparam int SPAN_W = 16;
  localparam int WORD_DEPTH = 6;
  localparam logic [2:0] WORD_MAX = 3'd6;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_WORD   = 2'd3
  } lex_mode_t;

  typedef enum logic [3:0] {
    KIND_ILLEGAL  = 4'd0,
    KIND_END      = 4'd1,
    KIND_LBRACE   = 4'd2,
    KIND_RBRACE   = 4'd3,
    KIND_LBRACKET = 4'd4,
    KIND_RBRACKET = 4'd5,
    KIND_COLON    = 4'd6,
    KIND_COMMA    = 4'd7,
    KIND_NUMBER   = 4'd8,
    KIND_STRING   = 4'd9,
    KIND_TRUE     = 4'd10,
    KIND_FALSE    = 4'd11,
    KIND_NULL     = 4'd12
  } token_kind_t;

  // Character codes.
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LOW_E    = 8'h65;
  localparam logic [7:0] CH_UP_E     = 8'h45;
  localparam logic [7:0] CH_NUL      = 8'h00;

  // Keywords, first character in entry zero.
  localparam logic [3:0][7:0] WORD_NULL  = {"l", "l", "u", "n"};
  localparam logic [3:0][7:0] WORD_TRUE  = {"e", "u", "r", "t"};
  localparam logic [4:0][7:0] WORD_FALSE = {"e", "s", "l", "a", "f"};

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    token_kind_t         token_kind;
    logic [SPAN_W-1:0]   span_start;
    logic [SPAN_W-1:0]   span_end;
    logic                run_last;
  } token_t;

  // All tokens caused by one input item, in order.
  typedef struct packed {
    logic [1:0]       count;
    token_t [2:0]     tok;
  } res_bundle_t;

  // Lexer control state carried from one item to the next.
  typedef struct packed {
    lex_mode_t                    mode;
    logic                         esc;
    logic [2:0]                   wlen;
    logic [WORD_DEPTH-1:0][7:0]   wbytes;
  } lex_ctl_t;

  localparam lex_ctl_t CTL_RESET = '{
    mode:   MODE_IDLE,
    esc:    1'b0,
    wlen:   3'd0,
    wbytes: '0
  };

endpackage

`default_nettype wire

// ===== src/jbt_lex_step.sv =====
// Combinational lexer step: one byte plus the current state gives the next
// state and every token that the byte causes. Depends on jbt_pkg.
`default_nettype none

module jbt_lex_step #(
  parameter int POSITION_BITS = 16
) (
  input  jbt_pkg::in_item_t         item,
  input  jbt_pkg::lex_ctl_t         ctl,
  input  logic [POSITION_BITS-1:0]  pos,
  input  logic [POSITION_BITS-1:0]  tstart,
  output jbt_pkg::lex_ctl_t         ctl_next,
  output logic [POSITION_BITS-1:0]  pos_next,
  output logic [POSITION_BITS-1:0]  tstart_next,
  output jbt_pkg::res_bundle_t      bundle
);
  import jbt_pkg::*;

  localparam int PW = POSITION_BITS;

  function automatic logic is_space(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic logic is_num(logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_PLUS ||
           b == CH_DOT || b == CH_LOW_E || b == CH_UP_E;
  endfunction

  function automatic token_kind_t word_kind(lex_ctl_t c);
    token_kind_t k;
    k = KIND_ILLEGAL;
    if (c.wlen == 3'd4) begin
      if (c.wbytes[3:0] == WORD_NULL) begin
        k = KIND_NULL;
      end else if (c.wbytes[3:0] == WORD_TRUE) begin
        k = KIND_TRUE;
      end
    end else if (c.wlen == 3'd5) begin
      if (c.wbytes[4:0] == WORD_FALSE) begin
        k = KIND_FALSE;
      end
    end
    return k;
  endfunction

  function automatic res_bundle_t push(res_bundle_t bi, token_kind_t k,
                                       logic [PW-1:0] s, logic [PW-1:0] e);
    res_bundle_t bo;
    bo = bi;
    bo.tok[bi.count].token_kind = k;
    bo.tok[bi.count].span_start = SPAN_W'(s);
    bo.tok[bi.count].span_end   = SPAN_W'(e);
    bo.tok[bi.count].run_last   = 1'b0;
    bo.count = bi.count + 2'd1;
    return bo;
  endfunction

  // Close whatever token is open; e is one past its last byte.
  function automatic res_bundle_t flush(res_bundle_t bi, lex_ctl_t c,
                                        logic [PW-1:0] ts, logic [PW-1:0] e);
    res_bundle_t bo;
    bo = bi;
    case (c.mode)
      MODE_STRING: bo = push(bi, KIND_ILLEGAL, '0, '0);
      MODE_NUMBER: bo = push(bi, KIND_NUMBER, ts, e);
      MODE_WORD:   bo = push(bi, word_kind(c), '0, '0);
      default:     bo = bi;
    endcase
    return bo;
  endfunction

  lex_ctl_t      c;
  logic [PW-1:0] ts;
  logic [PW-1:0] pn;
  logic [7:0]    b;
  logic          relex;
  res_bundle_t   bun;

  always_comb begin
    c     = ctl;
    ts    = tstart;
    b     = item.data_byte;
    pn    = pos + 1'b1;
    relex = 1'b0;
    bun   = '0;

    if (b == CH_NUL) begin
      bun = flush(bun, c, ts, pos);
      bun = push(bun, KIND_END, '0, '0);
      c   = CTL_RESET;
      ts  = '0;
      pn  = '0;
    end else begin
      case (c.mode)
        MODE_STRING: begin
          if (c.esc) begin
            c.esc = 1'b0;
          end else if (b == CH_BSLASH) begin
            c.esc = 1'b1;
          end else if (b == CH_QUOTE) begin
            bun    = push(bun, KIND_STRING, ts, pos);
            c.mode = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (!is_num(b)) begin
            bun    = push(bun, KIND_NUMBER, ts, pos);
            c.mode = MODE_IDLE;
            relex  = 1'b1;
          end
        end
        MODE_WORD: begin
          if (is_space(b) || b == CH_RBRACE || b == CH_RBRACKET || b == CH_COMMA) begin
            bun    = push(bun, word_kind(c), '0, '0);
            c.mode = MODE_IDLE;
            c.wlen = 3'd0;
            relex  = 1'b1;
          end else begin
            if (c.wlen < WORD_MAX) begin
              c.wbytes[c.wlen] = b;
              c.wlen = c.wlen + 3'd1;
            end
            if (c.wlen >= WORD_MAX) begin
              bun    = push(bun, KIND_ILLEGAL, '0, '0);
              c.mode = MODE_IDLE;
              c.wlen = 3'd0;
            end
          end
        end
        default: relex = 1'b1;
      endcase

      // The byte starts a new token from the between-tokens state.
      if (relex) begin
        case (b)
          CH_LBRACE:   bun = push(bun, KIND_LBRACE, '0, '0);
          CH_RBRACE:   bun = push(bun, KIND_RBRACE, '0, '0);
          CH_LBRACKET: bun = push(bun, KIND_LBRACKET, '0, '0);
          CH_RBRACKET: bun = push(bun, KIND_RBRACKET, '0, '0);
          CH_COLON:    bun = push(bun, KIND_COLON, '0, '0);
          CH_COMMA:    bun = push(bun, KIND_COMMA, '0, '0);
          CH_QUOTE: begin
            c.mode = MODE_STRING;
            c.esc  = 1'b0;
            ts     = pn;
          end
          default: begin
            if (is_space(b)) begin
              c.mode = MODE_IDLE;
            end else if (is_num(b)) begin
              c.mode = MODE_NUMBER;
              ts     = pos;
            end else begin
              c.mode      = MODE_WORD;
              c.wbytes[0] = b;
              c.wlen      = 3'd1;
            end
          end
        endcase
      end

      if (item.final_byte) begin
        bun = flush(bun, c, ts, pn);
        bun = push(bun, KIND_END, '0, '0);
        c   = CTL_RESET;
        ts  = '0;
        pn  = '0;
      end
    end

    if (bun.count != 2'd0) begin
      bun.tok[bun.count - 2'd1].run_last = 1'b1;
    end
  end

  assign ctl_next    = c;
  assign pos_next    = pn;
  assign tstart_next = ts;
  assign bundle      = bun;

endmodule

`default_nettype wire

// ===== src/json_byte_tokenizer.sv =====
// Top level of the JSON byte tokenizer: input register, lexer state,
// result register and token output sequencing. Depends on jbt_pkg and
// jbt_lex_step.
//
// Usage: JSON text enters one byte per item on the byte channel
// (byte_valid / byte_ready / byte_item). Tokens leave on the token channel
// (token_valid / token_ready / token_item), one token per item, with
// run_last set on the last token that a given byte causes.
// A byte that is zero, or that carries final_byte, closes the text with an
// end token and returns the lexer to its reset state.
// Path: an accepted byte waits in the input register until the result
// register is free; it is then lexed and its tokens are loaded into the
// result register, from which they are offered.
// Throughput: one byte per cycle while each byte causes at most one token
// and token_ready is high. A byte that causes more tokens holds the result
// register while the single output port drains them one per cycle.
// Stalls: while the receiver holds token_ready low, the current token stays
// on the port unchanged; one more byte waits in the input register and
// byte_ready drops only when both registers are occupied.
// Reset (rst, synchronous, active high) empties both registers, clears the
// lexer mode, the byte position and the token start offset.
`default_nettype none

module json_byte_tokenizer #(
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  jbt_pkg::in_item_t   byte_item,
  output logic                token_valid,
  input  logic                token_ready,
  output jbt_pkg::token_t     token_item
);
  import jbt_pkg::*;

  // Input register.
  logic     in_full;
  in_item_t in_reg;

  // Lexer state.
  lex_ctl_t                  ctl;
  logic [POSITION_BITS-1:0]  pos;
  logic [POSITION_BITS-1:0]  tstart;

  lex_ctl_t                  ctl_next;
  logic [POSITION_BITS-1:0]  pos_next;
  logic [POSITION_BITS-1:0]  tstart_next;
  res_bundle_t               bundle_next;

  // Result register and the index of the token being offered.
  res_bundle_t bun;
  logic [1:0]  idx;

  logic out_take;
  logic out_done;
  logic bun_free;
  logic advance;

  jbt_lex_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .item       (in_reg),
    .ctl        (ctl),
    .pos        (pos),
    .tstart     (tstart),
    .ctl_next   (ctl_next),
    .pos_next   (pos_next),
    .tstart_next(tstart_next),
    .bundle     (bundle_next)
  );

  assign token_valid = (bun.count != 2'd0);
  assign token_item  = bun.tok[idx];

  assign out_take   = token_valid && token_ready;
  assign out_done   = out_take && (idx == bun.count - 2'd1);
  assign bun_free   = (bun.count == 2'd0) || out_done;
  assign advance    = in_full && bun_free;
  assign byte_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_reg <= byte_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl    <= CTL_RESET;
      pos    <= '0;
      tstart <= '0;
    end else if (advance) begin
      ctl    <= ctl_next;
      pos    <= pos_next;
      tstart <= tstart_next;
    end
  end

  // The token slots carry no reset; only the count says what is valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      bun.count <= 2'd0;
      idx       <= 2'd0;
    end else if (advance) begin
      bun <= bundle_next;
      idx <= 2'd0;
    end else if (out_done) begin
      bun.count <= 2'd0;
      idx       <= 2'd0;
    end else if (out_take) begin
      idx <= idx + 2'd1;
    end
  end

`ifndef SYNTH
  // The offered token always lies inside the loaded result.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (idx < bun.count))
    else $error("token index beyond result count");

  // The last token of each result carries run_last.
  a_run_last: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (idx == bun.count - 2'd1)) |-> token_item.run_last)
    else $error("last token of a byte lacks run_last");

  // An open word always holds between one and five bytes.
  a_word_len: assert property (@(posedge clk) disable iff (rst)
    (ctl.mode == MODE_WORD) |-> ((ctl.wlen != 3'd0) && (ctl.wlen < WORD_MAX)))
    else $error("word length out of range while a word is open");

  // An end mark or the final byte returns the position to zero.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    (advance && (in_reg.final_byte || (in_reg.data_byte == CH_NUL)))
      |=> ((pos == '0) && (ctl.mode == MODE_IDLE)))
    else $error("lexer state not cleared after end of text");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_json_byte_tokenizer.sv =====
// Self-checking testbench for json_byte_tokenizer: directed JSON fragments,
// a long output stall and random token streams.
// Depends on jbt_pkg and the json_byte_tokenizer RTL only.
`default_nettype none

module tb_json_byte_tokenizer;
  import jbt_pkg::*;

  // A byte's first token passes the input and result registers before it can
  // be taken, and one byte can cause up to three tokens, so a short quiet
  // tail after the last expected token is enough to catch anything spurious.
  localparam int TAIL_CYCLES = 10;
  // Cycles with no item moving on either channel before the run is abandoned.
  // The long receiver stall below is far shorter than this.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_item_t  byte_item = '0;
  logic      token_valid;
  logic      token_ready = 1'b0;
  token_t    token_item;

  json_byte_tokenizer i_dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token_item  (token_item)
  );

  always #5 clk = ~clk;

  // Shared run control. gaps_on turns random idling on for both sides;
  // hold_request asks the receiver process for one long stall.
  bit gaps_on = 1'b1;
  int hold_request = 0;
  int bytes_sent = 0;
  int tokens_seen = 0;
  int mismatches = 0;

  // Tokens still owed by the block, oldest first.
  token_t expected_tokens[$];
  // Tokens caused by the byte being predicted right now.
  token_t byte_tokens[$];

  // Lexer state as the block should hold it.
  lex_mode_t   lx_mode = MODE_IDLE;
  logic [15:0] lx_pos = '0;
  logic [15:0] lx_start = '0;
  bit          lx_esc = 1'b0;
  logic [7:0]  lx_word [0:WORD_DEPTH-1];
  int          lx_wlen = 0;

  // ---------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------

  function automatic void put_token(token_kind_t k, logic [15:0] s, logic [15:0] e);
    token_t t;
    t.token_kind = k;
    t.span_start = s;
    t.span_end = e;
    t.run_last = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
  endfunction

  function automatic bit is_numch(logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_PLUS ||
           b == CH_DOT || b == CH_LOW_E || b == CH_UP_E;
  endfunction

  // Classify the bytes gathered for the current word.
  function automatic token_kind_t keyword_kind();
    if (lx_wlen == 4) begin
      if ({lx_word[0], lx_word[1], lx_word[2], lx_word[3]} == "null") return KIND_NULL;
      if ({lx_word[0], lx_word[1], lx_word[2], lx_word[3]} == "true") return KIND_TRUE;
    end else if (lx_wlen == 5) begin
      if ({lx_word[0], lx_word[1], lx_word[2], lx_word[3], lx_word[4]} == "false") begin
        return KIND_FALSE;
      end
    end
    return KIND_ILLEGAL;
  endfunction

  // Emit whatever token is still open; pos is where it ends.
  function automatic void close_open(logic [15:0] pos);
    case (lx_mode)
      MODE_STRING: put_token(KIND_ILLEGAL, '0, '0);
      MODE_NUMBER: put_token(KIND_NUMBER, lx_start, pos);
      MODE_WORD:   put_token(keyword_kind(), '0, '0);
      default: ;
    endcase
    lx_mode = MODE_IDLE;
  endfunction

  // A word that reaches six bytes is illegal at once.
  function automatic void word_add(logic [7:0] b);
    if (lx_wlen < WORD_DEPTH) begin
      lx_word[lx_wlen] = b;
      lx_wlen++;
    end
    if (lx_wlen >= WORD_DEPTH) begin
      put_token(KIND_ILLEGAL, '0, '0);
      lx_mode = MODE_IDLE;
      lx_wlen = 0;
    end
  endfunction

  // Lex a nonzero byte that arrives between tokens.
  function automatic void lex_between(logic [7:0] b, logic [15:0] p);
    case (b)
      CH_LBRACE:   put_token(KIND_LBRACE, '0, '0);
      CH_RBRACE:   put_token(KIND_RBRACE, '0, '0);
      CH_LBRACKET: put_token(KIND_LBRACKET, '0, '0);
      CH_RBRACKET: put_token(KIND_RBRACKET, '0, '0);
      CH_COLON:    put_token(KIND_COLON, '0, '0);
      CH_COMMA:    put_token(KIND_COMMA, '0, '0);
      CH_QUOTE: begin
        lx_mode = MODE_STRING;
        lx_start = p + 16'd1;
        lx_esc = 1'b0;
      end
      default: begin
        if (is_blank(b)) begin
        end else if (is_numch(b)) begin
          // This also catches a would-be word that starts with e or E.
          lx_mode = MODE_NUMBER;
          lx_start = p;
        end else begin
          lx_mode = MODE_WORD;
          lx_wlen = 0;
          word_add(b);
        end
      end
    endcase
  endfunction

  function automatic void clear_lexer();
    lx_mode = MODE_IDLE;
    lx_pos = '0;
    lx_start = '0;
    lx_esc = 1'b0;
    lx_wlen = 0;
  endfunction

  // Work out the tokens of one accepted byte and queue them.
  function automatic void predict_byte(logic [7:0] b, logic fin);
    logic [15:0] p;
    p = lx_pos;
    byte_tokens.delete();
    if (b == CH_NUL) begin
      // A zero byte ends the text; a final flag on it adds nothing more.
      close_open(p);
      put_token(KIND_END, '0, '0);
      clear_lexer();
    end else begin
      case (lx_mode)
        MODE_STRING: begin
          if (lx_esc) begin
            lx_esc = 1'b0;
          end else if (b == CH_BSLASH) begin
            lx_esc = 1'b1;
          end else if (b == CH_QUOTE) begin
            put_token(KIND_STRING, lx_start, p);
            lx_mode = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          // The byte that ends a number is lexed again in the same step.
          if (!is_numch(b)) begin
            put_token(KIND_NUMBER, lx_start, p);
            lx_mode = MODE_IDLE;
            lex_between(b, p);
          end
        end
        MODE_WORD: begin
          // Only blanks, closing brackets and commas end a word.
          if (is_blank(b) || b == CH_RBRACE || b == CH_RBRACKET || b == CH_COMMA) begin
            put_token(keyword_kind(), '0, '0);
            lx_mode = MODE_IDLE;
            lx_wlen = 0;
            lex_between(b, p);
          end else begin
            word_add(b);
          end
        end
        default: lex_between(b, p);
      endcase
      lx_pos = p + 16'd1;
      if (fin) begin
        close_open(lx_pos);
        put_token(KIND_END, '0, '0);
        clear_lexer();
      end
    end
    if (byte_tokens.size() > 0) begin
      byte_tokens[byte_tokens.size() - 1].run_last = 1'b1;
    end
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Byte sender
  // ---------------------------------------------------------------------

  // Offer one byte at a falling edge and hold it until a rising edge
  // sees byte_ready. Valid is only dropped when a gap is taken.
  task automatic send_byte(logic [7:0] b, logic fin);
    if (gaps_on) begin
      while ($urandom_range(99) < 27) begin
        @(negedge clk);
        byte_valid <= 1'b0;
      end
    end
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_item <= '{data_byte: b, final_byte: fin};
    do @(posedge clk); while (!byte_ready);
    predict_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_text(string s, logic fin_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], fin_at_end && (i == s.len() - 1));
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------

  // Ready changes only at falling edges. A hold request keeps it low for
  // the requested number of cycles while the sender keeps offering bytes.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        token_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        token_ready <= gaps_on ? ($urandom_range(99) >= 27) : 1'b1;
      end
    end
  end

  // Every token taken at a rising edge is compared with the oldest one owed.
  initial begin
    token_t want;
    forever begin
      @(posedge clk);
      if (!rst && token_valid && token_ready) begin
        tokens_seen++;
        if (expected_tokens.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("ERROR: unexpected token kind %0d span %0d..%0d last %0b",
                     token_item.token_kind, token_item.span_start,
                     token_item.span_end, token_item.run_last);
          end
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          if (token_item.token_kind !== want.token_kind ||
              token_item.span_start !== want.span_start ||
              token_item.span_end !== want.span_end ||
              token_item.run_last !== want.run_last) begin
            if (mismatches < MAX_REPORTS) begin
              $display("ERROR: token %0d: expected kind %0d span %0d..%0d last %0b,",
                       tokens_seen, want.token_kind, want.span_start, want.span_end,
                       want.run_last);
              $display("       got kind %0d span %0d..%0d last %0b",
                       token_item.token_kind, token_item.span_start,
                       token_item.span_end, token_item.run_last);
            end
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_valid && byte_ready) || (token_valid && token_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ERROR: no progress for %0d cycles, %0d tokens still owed",
             STALL_LIMIT, expected_tokens.size());
    $display("tb_json_byte_tokenizer failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_reset();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
  endtask

  // An opening brace, an empty string, a colon, a string with an escaped
  // quote, and a comma that also carries the final flag.
  task automatic test_structure_strings();
    send_text("{\"\":\"\\\"\"", 1'b0);
    send_byte(CH_COMMA, 1'b1);
  endtask

  // Brackets, a number that starts with e and is closed by a bracket that
  // is then lexed itself, null ended by a comma, a six-byte word that is
  // illegal on its sixth byte, and a zero byte as end mark.
  task automatic test_words_numbers();
    send_text("[e-9]null,falsex", 1'b0);
    send_byte(CH_NUL, 1'b0);
  endtask

  // true ended by blanks, then a number closed by a brace that is also the
  // final byte: that one byte causes three tokens.
  task automatic test_keywords_flush();
    send_text("true", 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_text("1", 1'b0);
    send_byte(CH_RBRACE, 1'b1);
  endtask

  // An all-ones byte as an illegal word, then an open string that a zero byte
  // with the final flag closes as illegal, followed by one end token only.
  task automatic test_odd_bytes();
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_text("\"a", 1'b0);
    send_byte(CH_NUL, 1'b1);
  endtask

  // Stall the receiver for a long stretch while a dense text keeps coming,
  // so both internal registers fill and byte_ready drops.
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    send_text("[1,2,{},[]]:,null}", 1'b1);
  endtask

  // Random texts: mostly well-formed tokens with random content, mixed
  // with loose noise bytes, open strings and random endings.
  task automatic test_random_text(int n_items, bit with_gaps);
    logic [7:0] txt[$];
    string kw;
    string numchars;
    int first;
    int frags;
    int sel;
    logic [7:0] c;
    gaps_on = with_gaps;
    numchars = "0123456789-+.eE";
    first = bytes_sent;
    while (bytes_sent - first < n_items) begin
      txt.delete();
      frags = $urandom_range(10, 3);
      for (int f = 0; f < frags; f++) begin
        sel = $urandom_range(99);
        if (sel < 20) begin
          case ($urandom_range(5))
            0: txt.push_back(CH_LBRACE);
            1: txt.push_back(CH_RBRACE);
            2: txt.push_back(CH_LBRACKET);
            3: txt.push_back(CH_RBRACKET);
            4: txt.push_back(CH_COLON);
            default: txt.push_back(CH_COMMA);
          endcase
        end else if (sel < 45) begin
          txt.push_back(CH_QUOTE);
          repeat ($urandom_range(5)) begin
            c = 8'($urandom_range(255, 1));
            if (c == CH_QUOTE) c = "q";
            txt.push_back(c);
            if (c == CH_BSLASH) txt.push_back(8'($urandom_range(255, 1)));
          end
          // Now and then the string is left open.
          if ($urandom_range(9) != 0) txt.push_back(CH_QUOTE);
        end else if (sel < 62) begin
          txt.push_back(numchars[$urandom_range(9)]);
          repeat ($urandom_range(5)) txt.push_back(numchars[$urandom_range(14)]);
        end else if (sel < 77) begin
          case ($urandom_range(2))
            0: kw = "true";
            1: kw = "false";
            default: kw = "null";
          endcase
          for (int j = 0; j < kw.len(); j++) txt.push_back(kw[j]);
          case ($urandom_range(3))
            0: txt.push_back(CH_SPACE);
            1: txt.push_back(CH_COMMA);
            2: txt.push_back(CH_RBRACE);
            default: txt.push_back(CH_RBRACKET);
          endcase
        end else if (sel < 85) begin
          repeat ($urandom_range(7, 1)) txt.push_back(8'($urandom_range("z", "a")));
        end else if (sel < 93) begin
          repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(3))
              0: txt.push_back(CH_SPACE);
              1: txt.push_back(CH_TAB);
              2: txt.push_back(CH_CR);
              default: txt.push_back(CH_LF);
            endcase
          end
        end else begin
          txt.push_back(8'($urandom_range(255, 1)));
        end
      end
      for (int i = 0; i < txt.size() - 1; i++) send_byte(txt[i], 1'b0);
      // End with the final flag, a zero byte, or a zero byte that is final.
      sel = $urandom_range(9);
      if (sel < 5) begin
        send_byte(txt[txt.size() - 1], 1'b1);
      end else begin
        send_byte(txt[txt.size() - 1], 1'b0);
        send_byte(CH_NUL, sel == 9);
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    test_reset();
    test_structure_strings();
    test_words_numbers();
    test_keywords_flush();
    test_odd_bytes();
    test_backpressure();
    test_random_text(60, 1'b1);
    test_random_text(25, 1'b0);

    @(negedge clk);
    byte_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes and checked %0d tokens: punctuation, strings, numbers,",
             bytes_sent, tokens_seen);
    $display("keywords, illegal words, end marks and a long output stall.");
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("tb_json_byte_tokenizer passed");
    end else begin
      $display("%0d mismatches, %0d tokens never arrived", mismatches,
               expected_tokens.size());
      $display("tb_json_byte_tokenizer failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/jbt_pkg.sv
src/jbt_lex_step.sv
src/json_byte_tokenizer.sv
sim/tb_json_byte_tokenizer.sv
